// ===== hw/rtl/rpdf_pkg.sv =====
// Shared types, constants and register codes for the RC pulse deadzone filter.
package rpdf_pkg;

  // Field widths
  localparam int unsigned PulseW   = 16;
  localparam int unsigned LevelW   = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  // Serial divider geometry
  localparam int unsigned DivDendW  = 22;
  localparam int unsigned DivSorW   = 10;
  localparam int unsigned CntW      = 5;
  localparam int unsigned ShapeSteps  = 22;
  localparam int unsigned SmoothSteps = 15;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgDeadzone  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgWeight    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFwdMin    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTurnMin   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPulseMax  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLostLevel = 3'd5;

  // Register reset values
  localparam logic [8:0]        DeadzoneRst  = 9'd50;
  localparam logic [3:0]        WeightRst    = 4'd5;
  localparam logic [11:0]       FwdMinRst    = 12'd950;
  localparam logic [11:0]       TurnMinRst   = 12'd920;
  localparam logic [11:0]       PulseMaxRst  = 12'd2050;
  localparam logic [LevelW-1:0] LostLevelRst = 11'd500;
  localparam logic [LevelW-1:0] AverageRst   = 11'd1500;

  // Shaping constants
  localparam logic [8:0]        DeadzoneCap = 9'd400;
  localparam logic [LevelW-1:0] OutLow      = 11'd1000;
  localparam logic [LevelW-1:0] OutHigh     = 11'd2000;

  // Controller state codes
  localparam int unsigned StateW = 3;
  localparam logic [StateW-1:0] StIdle   = 3'd0;
  localparam logic [StateW-1:0] StCenter = 3'd1;
  localparam logic [StateW-1:0] StLoad1  = 3'd2;
  localparam logic [StateW-1:0] StDiv1   = 3'd3;
  localparam logic [StateW-1:0] StLoad2  = 3'd4;
  localparam logic [StateW-1:0] StDiv2   = 3'd5;
  localparam logic [StateW-1:0] StFinish = 3'd6;

  typedef struct packed {
    logic [PulseW-1:0] fwd_pulse_us;
    logic [PulseW-1:0] turn_pulse_us;
  } in_word_t;

  typedef struct packed {
    logic              accepted;
    logic [LevelW-1:0] fwd_level;
    logic [LevelW-1:0] turn_level;
    logic              signal_lost;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic center;
    logic load_shape;
    logic load_smooth;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ok;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/rpdf_divider.sv =====
// Restoring serial divider, one quotient bit per step.
module rpdf_divider (
  input  logic                           clk_i,
  input  logic                           load_i,
  input  logic                           step_i,
  input  logic [rpdf_pkg::DivDendW-1:0]  dividend_i,
  input  logic [rpdf_pkg::DivSorW-1:0]   divisor_i,
  output logic [rpdf_pkg::DivDendW-1:0]  quot_o
);

  logic [rpdf_pkg::DivDendW-1:0] q_q, q_d;
  logic [rpdf_pkg::DivSorW-1:0]  r_q, r_d;
  logic [rpdf_pkg::DivSorW-1:0]  sor_q, sor_d;
  logic [rpdf_pkg::DivSorW:0]    trial;
  logic                          fits;

  // Shift the next dividend bit into the partial remainder
  assign trial = {r_q, q_q[rpdf_pkg::DivDendW-1]};
  assign fits  = trial >= {1'b0, sor_q};

  always_comb begin
    q_d   = q_q;
    r_d   = r_q;
    sor_d = sor_q;
    if (load_i) begin
      q_d   = dividend_i;
      r_d   = '0;
      sor_d = divisor_i;
    end else if (step_i) begin
      q_d = {q_q[rpdf_pkg::DivDendW-2:0], fits};
      if (fits) begin
        r_d = rpdf_pkg::DivSorW'(trial - {1'b0, sor_q});
      end else begin
        r_d = trial[rpdf_pkg::DivSorW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    r_q   <= r_d;
    sor_q <= sor_d;
  end

  assign quot_o = q_q;

endmodule

// ===== hw/rtl/rpdf_datapath.sv =====
// Datapath: config registers, pulse shaping, dividers, averages, output register.
module rpdf_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rpdf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rpdf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  rpdf_pkg::in_word_t             in_word_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output rpdf_pkg::out_word_t            out_word_o,
  input  rpdf_pkg::dp_cmd_t              cmd_i,
  output rpdf_pkg::dp_status_t           status_o
);

  // Config registers
  logic [8:0]                  deadzone_q;
  logic [3:0]                  weight_q;
  logic [11:0]                 fwd_min_q, turn_min_q, pulse_max_q;
  logic [rpdf_pkg::LevelW-1:0] lost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q  <= rpdf_pkg::DeadzoneRst;
      weight_q    <= rpdf_pkg::WeightRst;
      fwd_min_q   <= rpdf_pkg::FwdMinRst;
      turn_min_q  <= rpdf_pkg::TurnMinRst;
      pulse_max_q <= rpdf_pkg::PulseMaxRst;
      lost_q      <= rpdf_pkg::LostLevelRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rpdf_pkg::CfgDeadzone:  deadzone_q  <= cfg_wdata_i[8:0];
        rpdf_pkg::CfgWeight:    weight_q    <= cfg_wdata_i[3:0];
        rpdf_pkg::CfgFwdMin:    fwd_min_q   <= cfg_wdata_i;
        rpdf_pkg::CfgTurnMin:   turn_min_q  <= cfg_wdata_i;
        rpdf_pkg::CfgPulseMax:  pulse_max_q <= cfg_wdata_i;
        rpdf_pkg::CfgLostLevel: lost_q      <= cfg_wdata_i[rpdf_pkg::LevelW-1:0];
        default: ;
      endcase
    end
  end

  // Centered, deadzone-removed pulse, offset so the low end of the span is zero
  function automatic logic signed [12:0] span_offset(logic [11:0] pulse, logic [8:0] dz);
    logic signed [12:0] p;
    logic signed [12:0] dzs;
    logic signed [12:0] res;
    p   = $signed({1'b0, pulse}) - 13'sd1500;
    dzs = $signed({4'b0, dz});
    if (p > dzs) begin
      res = p - dzs;
    end else if (p < -dzs) begin
      res = p + dzs;
    end else begin
      res = '0;
    end
    return res + 13'sd500 - dzs;
  endfunction

  // Captured word and per-frame registers
  rpdf_pkg::in_word_t    word_q;
  logic                  ok_q;
  logic signed [12:0]    fx_q, tx_q;
  logic [8:0]            dz;
  logic                  win_ok;

  assign dz = (deadzone_q > rpdf_pkg::DeadzoneCap) ? rpdf_pkg::DeadzoneCap : deadzone_q;

  // Both windows checked on the full 16-bit pulse
  assign win_ok = (word_q.fwd_pulse_us  >= {4'b0, fwd_min_q})  &&
                  (word_q.fwd_pulse_us  <= {4'b0, pulse_max_q}) &&
                  (word_q.turn_pulse_us >= {4'b0, turn_min_q}) &&
                  (word_q.turn_pulse_us <= {4'b0, pulse_max_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      word_q <= in_word_i;
    end
    if (cmd_i.center) begin
      ok_q <= win_ok;
      fx_q <= span_offset(word_q.fwd_pulse_us[11:0], dz);
      tx_q <= span_offset(word_q.turn_pulse_us[11:0], dz);
    end
  end

  // Divider operands
  logic [rpdf_pkg::DivSorW-1:0]   span;
  logic [rpdf_pkg::DivDendW-1:0]  f_scaled, t_scaled;
  logic [rpdf_pkg::DivDendW-1:0]  f_quot, t_quot;
  logic [rpdf_pkg::LevelW-1:0]    f_fresh, t_fresh;
  logic [14:0]                    f_sum, t_sum;
  logic [4:0]                     wdiv;
  logic [rpdf_pkg::DivDendW-1:0]  f_dend, t_dend;
  logic [rpdf_pkg::DivSorW-1:0]   f_sor, t_sor;
  logic                           div_load;
  logic [rpdf_pkg::LevelW-1:0]    fwd_avg_q, turn_avg_q;

  assign span     = 10'd1000 - {dz, 1'b0};
  // Non-positive offsets scale to zero, which clamps to the low end
  assign f_scaled = (fx_q > 13'sd0) ? {10'b0, fx_q[11:0]} * 22'd1000 : '0;
  assign t_scaled = (tx_q > 13'sd0) ? {10'b0, tx_q[11:0]} * 22'd1000 : '0;

  // Rescaled sample, clamped to the top of the range
  assign f_fresh = (f_quot > 22'd1000) ? rpdf_pkg::OutHigh
                                       : rpdf_pkg::OutLow + {1'b0, f_quot[9:0]};
  assign t_fresh = (t_quot > 22'd1000) ? rpdf_pkg::OutHigh
                                       : rpdf_pkg::OutLow + {1'b0, t_quot[9:0]};

  // Weighted sum for the running average
  assign f_sum = {4'b0, fwd_avg_q}  + ({4'b0, f_fresh} * {11'b0, weight_q});
  assign t_sum = {4'b0, turn_avg_q} + ({4'b0, t_fresh} * {11'b0, weight_q});
  assign wdiv  = {1'b0, weight_q} + 5'd1;

  always_comb begin
    f_dend = f_scaled;
    t_dend = t_scaled;
    f_sor  = span;
    t_sor  = span;
    if (cmd_i.load_smooth) begin
      f_dend = {f_sum, 7'b0};
      t_dend = {t_sum, 7'b0};
      f_sor  = {5'b0, wdiv};
      t_sor  = {5'b0, wdiv};
    end
  end

  assign div_load = cmd_i.load_shape | cmd_i.load_smooth;

  rpdf_divider u_div_fwd (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (cmd_i.div_step),
    .dividend_i (f_dend),
    .divisor_i  (f_sor),
    .quot_o     (f_quot)
  );

  rpdf_divider u_div_turn (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (cmd_i.div_step),
    .dividend_i (t_dend),
    .divisor_i  (t_sor),
    .quot_o     (t_quot)
  );

  // New averages: smoothed quotient on an accepted frame, held otherwise
  logic [rpdf_pkg::LevelW-1:0] fwd_avg_d, turn_avg_d;

  assign fwd_avg_d  = ok_q ? f_quot[rpdf_pkg::LevelW-1:0] : fwd_avg_q;
  assign turn_avg_d = ok_q ? t_quot[rpdf_pkg::LevelW-1:0] : turn_avg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_avg_q  <= rpdf_pkg::AverageRst;
      turn_avg_q <= rpdf_pkg::AverageRst;
    end else if (cmd_i.commit) begin
      fwd_avg_q  <= fwd_avg_d;
      turn_avg_q <= turn_avg_d;
    end
  end

  // Output register
  logic                out_valid_q;
  rpdf_pkg::out_word_t out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_word_q.accepted    <= ok_q;
      out_word_q.fwd_level   <= fwd_avg_d;
      out_word_q.turn_level  <= turn_avg_d;
      out_word_q.signal_lost <= (fwd_avg_d < lost_q) || (turn_avg_d < lost_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_word_o        = out_word_q;
  assign status_o.ok       = ok_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

// ===== hw/rtl/rpdf_ctrl.sv =====
// Controller state machine: sequences capture, shaping divide, smoothing divide, commit.
module rpdf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rpdf_pkg::dp_status_t  status_i,
  output rpdf_pkg::dp_cmd_t     cmd_o
);

  logic [rpdf_pkg::StateW-1:0] state_q, state_d;
  logic [rpdf_pkg::CntW-1:0]   cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      rpdf_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = rpdf_pkg::StCenter;
        end
      end
      rpdf_pkg::StCenter: begin
        cmd_o.center = 1'b1;
        state_d      = rpdf_pkg::StLoad1;
      end
      rpdf_pkg::StLoad1: begin
        // rejected frames skip both divides
        if (status_i.ok) begin
          cmd_o.load_shape = 1'b1;
          cnt_d            = '0;
          state_d          = rpdf_pkg::StDiv1;
        end else begin
          state_d = rpdf_pkg::StFinish;
        end
      end
      rpdf_pkg::StDiv1: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == rpdf_pkg::CntW'(rpdf_pkg::ShapeSteps - 1)) begin
          state_d = rpdf_pkg::StLoad2;
        end
      end
      rpdf_pkg::StLoad2: begin
        cmd_o.load_smooth = 1'b1;
        cnt_d             = '0;
        state_d           = rpdf_pkg::StDiv2;
      end
      rpdf_pkg::StDiv2: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == rpdf_pkg::CntW'(rpdf_pkg::SmoothSteps - 1)) begin
          state_d = rpdf_pkg::StFinish;
        end
      end
      rpdf_pkg::StFinish: begin
        // wait for room in the output register
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = rpdf_pkg::StIdle;
        end
      end
      default: begin
        state_d = rpdf_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpdf_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != rpdf_pkg::StIdle);

endmodule

// ===== hw/rtl/rc_pulse_deadzone_filter_top.sv =====
// Top level of the RC pulse deadzone and smoothing filter.
//
//   channel  direction  handshake                   word
//   in       input      in_valid_i / in_stall_o     in_word_i  (fwd, turn pulse widths)
//   out      output     out_valid_o / out_stall_i   out_word_o (accepted, levels, lost)
//   cfg      input      cfg_we_i, cfg_idx_i         cfg_wdata_i
//
// An accepted frame runs the 22-step shaping divide and the 15-step smoothing
// divide, each run on two one-bit-per-cycle dividers (one per channel). A
// rejected frame skips both divides. The input stays stalled until the frame commits.
// Reset restores the register defaults and centers both averages at 1500.
// The output register holds one word; while it is stalled, a finished frame
// waits in the controller and the input stays stalled.
module rc_pulse_deadzone_filter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rpdf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rpdf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rpdf_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rpdf_pkg::out_word_t            out_word_o
);

  rpdf_pkg::dp_cmd_t    cmd;
  rpdf_pkg::dp_status_t status;

  rpdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rpdf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
